// File: hw/rtl/mfa_pkg.sv
// ---------------------------------------------------------------------------
// mfa_pkg
// Shared types and constants for the multichannel FIR accumulate core.
// ---------------------------------------------------------------------------
package mfa_pkg;

   localparam int TAPS_DEFAULT        = 1024;
   localparam int CHANNELS_DEFAULT    = 2;
   localparam int SAMPLE_BITS_DEFAULT = 24;

   // fixed field widths of the request beat
   localparam int CHANNEL_BITS   = 1;
   localparam int TAP_INDEX_BITS = 10;

   // read -> multiply -> accumulate: cycles after the last tap issue
   localparam int MAC_LATENCY = 2;

   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND,
      ST_SAT
   } state_type;

   typedef struct packed {
      logic start;     // accept a sample beat: write history, clear accumulator
      logic load;      // accept a coefficient beat
      logic issue;     // read one tap pair
      logic round;     // add addend and rounding constant
      logic sat_load;  // saturate into the output register
   } cmd_type;

   typedef struct packed {
      logic sample_ok;
      logic load_ok;
      logic out_free;
   } status_type;

endpackage

// File: hw/rtl/mfa_ctrl.sv
// ---------------------------------------------------------------------------
// mfa_ctrl
// Sequencer: accepts loads while idle, walks the taps of one sample, drains
// the MAC pipe, rounds and hands the result to the output register.
// ---------------------------------------------------------------------------
module mfa_ctrl #(
   parameter int TAPS = mfa_pkg::TAPS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  mfa_pkg::status_type             status,
   output mfa_pkg::cmd_type                cmd,
   output logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] tap,
   output mfa_pkg::state_type              state
);

   localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int DW = (mfa_pkg::MAC_LATENCY > 1) ? $clog2(mfa_pkg::MAC_LATENCY) : 1;

   mfa_pkg::state_type state_ff, state_in;
   logic [IW-1:0]      tap_ff, tap_in;
   logic [DW-1:0]      drain_ff, drain_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfa_pkg::ST_IDLE;
         tap_ff   <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         drain_ff <= drain_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      drain_in  = drain_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mfa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = status.sample_ok;
               cmd.load  = status.load_ok;
               if (status.sample_ok) begin
                  state_in = mfa_pkg::ST_MAC;
                  tap_in   = '0;
               end
            end
         end
         mfa_pkg::ST_MAC: begin
            cmd.issue = 1'b1;
            if (tap_ff == IW'(TAPS - 1)) begin
               state_in = mfa_pkg::ST_DRAIN;
               drain_in = '0;
            end else begin
               tap_in = tap_ff + IW'(1);
            end
         end
         mfa_pkg::ST_DRAIN: begin
            if (drain_ff == DW'(mfa_pkg::MAC_LATENCY - 1)) begin
               state_in = mfa_pkg::ST_ROUND;
            end else begin
               drain_in = drain_ff + DW'(1);
            end
         end
         mfa_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = mfa_pkg::ST_SAT;
         end
         mfa_pkg::ST_SAT: begin
            if (status.out_free) begin
               cmd.sat_load = 1'b1;
               state_in     = mfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mfa_pkg::ST_IDLE;
         end
      endcase
   end

   assign tap   = tap_ff;
   assign state = state_ff;

endmodule

// File: hw/rtl/mfa_datapath.sv
// ---------------------------------------------------------------------------
// mfa_datapath
// Coefficient and history memories, per-channel write pointers and fill
// counts, one MAC lane, rounding, saturation and the output register.
// ---------------------------------------------------------------------------
module mfa_datapath #(
   parameter int TAPS        = mfa_pkg::TAPS_DEFAULT,
   parameter int CHANNELS    = mfa_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = mfa_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_op,
   input  logic [mfa_pkg::CHANNEL_BITS-1:0]        req_channel,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample_in,
   input  logic signed [SAMPLE_BITS-1:0]           req_addend,
   input  logic [mfa_pkg::TAP_INDEX_BITS-1:0]      req_tap_index,
   input  logic signed [SAMPLE_BITS-1:0]           req_coef_value,
   input  mfa_pkg::cmd_type                        cmd,
   input  logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] tap,
   output mfa_pkg::status_type                     status,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]           rsp_filtered,
   output logic                                    rsp_clipped
);

   localparam int SB    = SAMPLE_BITS;
   localparam int F     = SB - 1;
   localparam int IW    = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH = CHANNELS * TAPS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW    = $clog2(TAPS + 1);
   localparam int PW    = 2 * SB;
   localparam int ACC_W = PW + $clog2(TAPS) + 2;

   // memories
   logic [SB-1:0] hist_mem [DEPTH];
   logic [SB-1:0] coef_mem [DEPTH];

   // per-channel pointers; fill count marks history entries written since reset
   logic [IW-1:0] wp_ff   [CHANNELS];
   logic [FW-1:0] fill_ff [CHANNELS];

   logic [CIW-1:0] chi;
   logic           ch_ok;
   logic [AW-1:0]  req_base;
   logic [AW-1:0]  hist_wr_addr, hist_rd_addr, coef_wr_addr, coef_rd_addr;
   logic [FW-1:0]  fill_next;

   logic [AW-1:0]           base_ff;
   logic [IW-1:0]           idx_ff;
   logic [FW-1:0]           fill_cur_ff;
   logic signed [SB-1:0]    addend_ff;

   logic                    rd_vld_ff, mask_ff;
   logic signed [SB-1:0]    coef_rd_ff, hist_rd_ff, hist_x;
   logic                    prod_vld_ff;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic [ACC_W-1:0]        acc_ff, rnd;

   logic [ACC_W-2*SB+1:0]   acc_top;
   logic                    fits;
   logic                    rsp_valid_ff;
   logic signed [SB-1:0]    rsp_filtered_ff;
   logic                    rsp_clipped_ff;

   assign chi       = CIW'(req_channel);
   assign ch_ok     = int'(req_channel) < CHANNELS;
   assign req_base  = AW'(AW'(req_channel) * AW'(TAPS));
   assign fill_next = (fill_ff[chi] == FW'(TAPS)) ? fill_ff[chi] : fill_ff[chi] + FW'(1);

   assign hist_wr_addr = req_base + AW'(wp_ff[chi]);
   assign coef_wr_addr = req_base + AW'(req_tap_index);
   assign hist_rd_addr = base_ff + AW'(idx_ff);
   assign coef_rd_addr = base_ff + AW'(tap);

   always_comb begin
      status.sample_ok = (req_op == mfa_pkg::OP_FILTER) && ch_ok;
      status.load_ok   = (req_op == mfa_pkg::OP_LOAD) && ch_ok &&
                         (int'(req_tap_index) < TAPS);
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         hist_mem[hist_wr_addr] <= req_sample_in;
      end
      if (cmd.issue) begin
         hist_rd_ff <= hist_mem[hist_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         coef_mem[coef_wr_addr] <= req_coef_value;
      end
      if (cmd.issue) begin
         coef_rd_ff <= coef_mem[coef_rd_addr];
      end
   end

   // per-channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            wp_ff[c]   <= '0;
            fill_ff[c] <= '0;
         end
      end else if (cmd.start) begin
         wp_ff[chi]   <= (wp_ff[chi] == IW'(TAPS - 1)) ? '0 : wp_ff[chi] + IW'(1);
         fill_ff[chi] <= fill_next;
      end
   end

   // item context
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         base_ff     <= req_base;
         idx_ff      <= wp_ff[chi];
         fill_cur_ff <= fill_next;
         addend_ff   <= req_addend;
      end else if (cmd.issue) begin
         idx_ff <= (idx_ff == '0) ? IW'(TAPS - 1) : idx_ff - IW'(1);
      end
   end

   // MAC pipe control
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   // never-written history entries read as zero
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         mask_ff <= FW'(idx_ff) < fill_cur_ff;
      end
   end

   assign hist_x  = mask_ff ? hist_rd_ff : '0;
   assign prod_in = coef_rd_ff * hist_x;

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prod_ff <= prod_in;
      end
   end

   // addend * 2^F plus half an LSB, in one word
   assign rnd = {{(ACC_W - SB - F){addend_ff[SB-1]}}, addend_ff, 1'b1, {(F - 1){1'b0}}};

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + {{(ACC_W - PW){prod_ff[PW-1]}}, prod_ff};
      end else if (cmd.round) begin
         acc_ff <= acc_ff + rnd;
      end
   end

   // result fits when all bits above the kept field match its sign
   assign acc_top = acc_ff[ACC_W-1:2*SB-2];
   assign fits    = (&acc_top) || !(|acc_top);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.sat_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sat_load) begin
         if (fits) begin
            rsp_filtered_ff <= acc_ff[F+SB-1:F];
            rsp_clipped_ff  <= 1'b0;
         end else if (acc_ff[ACC_W-1]) begin
            rsp_filtered_ff <= {1'b1, {(SB - 1){1'b0}}};
            rsp_clipped_ff  <= 1'b1;
         end else begin
            rsp_filtered_ff <= {1'b0, {(SB - 1){1'b1}}};
            rsp_clipped_ff  <= 1'b1;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_clipped  = rsp_clipped_ff;

endmodule

// File: hw/rtl/multichannel_fir_accumulate_core.sv
// ---------------------------------------------------------------------------
// multichannel_fir_accumulate_core
// Per-channel direct-form FIR with addend, Q1.F in and out, round half up
// and saturation.
// ---------------------------------------------------------------------------
// Usage:
//   req_* beats are coefficient loads (req_op = load) or samples (filter).
//   A load writes one coefficient and returns nothing. Load all
//   TAPS coefficients of a channel before its first sample.
//   A sample beat writes the history, then one MAC runs one tap per cycle
//   from a single read port per memory. The result (rsp_filtered,
//   rsp_clipped) lands in the output register as the sequencer leaves its
//   saturate state, and req_ready rises in that same cycle; the core takes
//   no new beat until it is through with the current sample.
//   Beats for a channel at or beyond CHANNELS, and loads with tap index at or
//   beyond TAPS, are dropped with no response.
//   Reset clears the write pointers and the per-channel fill counts, so the
//   history reads as zero right away; no clearing pass is needed.
//   Coefficients are undefined after reset.
//   A stalled rsp_ready holds the result; the next sample may be accepted
//   and computed meanwhile and waits only to hand over its result.
// ---------------------------------------------------------------------------
module multichannel_fir_accumulate_core #(
   parameter int TAPS        = mfa_pkg::TAPS_DEFAULT,
   parameter int CHANNELS    = mfa_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = mfa_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [mfa_pkg::CHANNEL_BITS-1:0]    req_channel,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   input  logic signed [SAMPLE_BITS-1:0]       req_addend,
   input  logic [mfa_pkg::TAP_INDEX_BITS-1:0]  req_tap_index,
   input  logic signed [SAMPLE_BITS-1:0]       req_coef_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_filtered,
   output logic                                rsp_clipped
);

   localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;

   mfa_pkg::cmd_type    cmd;
   mfa_pkg::status_type status;
   mfa_pkg::state_type  state;
   logic [IW-1:0]       tap;

   mfa_ctrl #(
      .TAPS (TAPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .tap       (tap),
      .state     (state)
   );

   mfa_datapath #(
      .TAPS        (TAPS),
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_op),
      .req_channel    (req_channel),
      .req_sample_in  (req_sample_in),
      .req_addend     (req_addend),
      .req_tap_index  (req_tap_index),
      .req_coef_value (req_coef_value),
      .cmd            (cmd),
      .tap            (tap),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_filtered   (rsp_filtered),
      .rsp_clipped    (rsp_clipped)
   );

   // a coefficient load never starts a filter pass
   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == mfa_pkg::OP_LOAD) |=>
      (state == mfa_pkg::ST_IDLE))
      else $error("coefficient load left idle");

   // every pass starts at tap zero
   a_first_tap_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && $past(state) == mfa_pkg::ST_IDLE) |-> (tap == '0))
      else $error("filter pass did not start at tap zero");

   // a saturated result always shows up on the response port
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.sat_load |=> rsp_valid)
      else $error("result load lost");

   // a pending result is never overwritten
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state == mfa_pkg::ST_SAT && rsp_valid && !rsp_ready) |=>
      (state == mfa_pkg::ST_SAT))
      else $error("result handed over while response stalled");

endmodule

// File: verif/multichannel_fir_accumulate_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// multichannel_fir_accumulate_core_tb
// Self-checking bench for the two-channel FIR accumulate core. A behavioral
// FIR with its own history and coefficient copies predicts every sample beat,
// and responses are checked in order. Covers round half up, saturation,
// coefficient edges, a long response stall, bursty and steady traffic.
// ---------------------------------------------------------------------------
module multichannel_fir_accumulate_core_tb;

   localparam int TAPS            = mfa_pkg::TAPS_DEFAULT;
   localparam int CHANNELS        = mfa_pkg::CHANNELS_DEFAULT;
   localparam int SBITS           = mfa_pkg::SAMPLE_BITS_DEFAULT;
   localparam int CH_BITS         = mfa_pkg::CHANNEL_BITS;
   localparam int TAP_BITS        = mfa_pkg::TAP_INDEX_BITS;
   localparam int FRAC            = SBITS - 1;
   localparam int HOLD_OFF_CYCLES = 4 * (TAPS + 4);
   localparam int WATCHDOG_CYCLES = 40000;
   localparam int RANDOM_ITEMS    = 580;

   typedef logic signed [SBITS-1:0] word_type;

   localparam word_type WORD_MAX  = word_type'((1 << FRAC) - 1);
   localparam word_type WORD_MIN  = word_type'(-(1 << FRAC));
   localparam word_type COEF_HALF = word_type'(1 << (FRAC - 1));

   typedef struct {
      logic                op;
      logic [CH_BITS-1:0]  channel;
      word_type            sample_in;
      word_type            addend;
      logic [TAP_BITS-1:0] tap_index;
      word_type            coef_value;
   } req_beat_type;

   typedef struct {
      word_type filtered;
      logic     clipped;
   } fir_result_type;

   typedef enum {
      COEFS_HALF_DELTA,
      COEFS_ALL_MIN,
      COEFS_ALL_MAX,
      COEFS_SPARSE,
      COEFS_SMALL,
      COEFS_FULL
   } coef_set_type;

   typedef enum { TX_STEADY, TX_BURSTY, TX_LONG_GAPS } tx_mode_type;
   typedef enum { RX_ALWAYS, RX_STALLS } rx_mode_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic                req_op         = mfa_pkg::OP_FILTER;
   logic [CH_BITS-1:0]  req_channel    = '0;
   word_type            req_sample_in  = '0;
   word_type            req_addend     = '0;
   logic [TAP_BITS-1:0] req_tap_index  = '0;
   word_type            req_coef_value = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   word_type            rsp_filtered;
   logic                rsp_clipped;

   // bench copy of the filter state
   word_type       coef_mem  [CHANNELS][TAPS];
   word_type       hist_mem  [CHANNELS][TAPS];
   int             hist_head [CHANNELS];
   coef_set_type   chan_set  [CHANNELS];
   fir_result_type pending_outputs [$];

   int          load_count   = 0;
   int          sample_count = 0;
   int          result_count = 0;
   int          clip_count   = 0;
   int          fail_count   = 0;
   int          idle_cycles  = 0;
   int          burst_left   = 0;
   tx_mode_type tx_mode      = TX_BURSTY;
   rx_mode_type rx_mode      = RX_STALLS;
   int          rx_hold_req  = 0;
   int          rx_hold_seen = 0;
   int          rx_hold_left = 0;
   int          rx_run_left  = 0;
   logic        rx_stalling  = 1'b0;

   multichannel_fir_accumulate_core #(
      .TAPS        (TAPS),
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SBITS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_channel    (req_channel),
      .req_sample_in  (req_sample_in),
      .req_addend     (req_addend),
      .req_tap_index  (req_tap_index),
      .req_coef_value (req_coef_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_filtered   (rsp_filtered),
      .rsp_clipped    (rsp_clipped)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shift the sample in, run all taps, add addend and half an LSB, floor,
   // saturate. Sums stay well inside 64 bits at these widths.
   function automatic fir_result_type fir_output(input int ch, input word_type smp,
                                                 input word_type add);
      fir_result_type res;
      longint         acc;
      longint         q;
      int             idx;
      int             k;
      hist_mem[ch][hist_head[ch]] = smp;
      idx = hist_head[ch];
      acc = longint'(add) * (longint'(1) << FRAC) + (longint'(1) << (FRAC - 1));
      for (k = 0; k < TAPS; k++) begin
         acc += longint'(coef_mem[ch][k]) * longint'(hist_mem[ch][idx]);
         idx = (idx == 0) ? TAPS - 1 : idx - 1;
      end
      hist_head[ch] = (hist_head[ch] + 1) % TAPS;
      q = acc >>> FRAC;
      res.clipped = 1'b1;
      if (q > longint'(WORD_MAX)) begin
         res.filtered = WORD_MAX;
      end else if (q < longint'(WORD_MIN)) begin
         res.filtered = WORD_MIN;
      end else begin
         res.filtered = word_type'(q);
         res.clipped  = 1'b0;
      end
      return res;
   endfunction

   function automatic word_type pick_word();
      case ($urandom_range(0, 11))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         3: return word_type'(-1);
         4: return word_type'(1);
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic word_type coef_for(input coef_set_type kind, input int k);
      case (kind)
         COEFS_HALF_DELTA: return (k == 0) ? COEF_HALF : '0;
         COEFS_ALL_MIN:    return WORD_MIN;
         COEFS_ALL_MAX:    return WORD_MAX;
         COEFS_SPARSE:     return ($urandom_range(0, 63) == 0) ? word_type'($urandom) : '0;
         COEFS_SMALL:      return word_type'(int'($urandom_range(0, 16383)) - 8192);
         default:          return word_type'($urandom);
      endcase
   endfunction

   // unused fields of a beat carry random junk
   function automatic req_beat_type sample_beat(input int ch, input word_type smp,
                                                input word_type add);
      req_beat_type b;
      b.op         = mfa_pkg::OP_FILTER;
      b.channel    = ch[CH_BITS-1:0];
      b.sample_in  = smp;
      b.addend     = add;
      b.tap_index  = TAP_BITS'($urandom);
      b.coef_value = word_type'($urandom);
      return b;
   endfunction

   function automatic req_beat_type load_beat(input int ch, input int tap,
                                              input word_type coef);
      req_beat_type b;
      b.op         = mfa_pkg::OP_LOAD;
      b.channel    = ch[CH_BITS-1:0];
      b.sample_in  = word_type'($urandom);
      b.addend     = word_type'($urandom);
      b.tap_index  = tap[TAP_BITS-1:0];
      b.coef_value = coef;
      return b;
   endfunction

   // Offer one beat, hold it until accepted, then update the bench state.
   // Valid is only dropped at the start of a gap, never right after a beat.
   task automatic send_beat(input req_beat_type b);
      int gap;
      gap = 0;
      if (tx_mode != TX_STEADY) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (tx_mode == TX_LONG_GAPS && $urandom_range(0, 7) == 0)
               gap = $urandom_range(7, TAPS + 80);
         end
         burst_left--;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= b.op;
      req_channel    <= b.channel;
      req_sample_in  <= b.sample_in;
      req_addend     <= b.addend;
      req_tap_index  <= b.tap_index;
      req_coef_value <= b.coef_value;
      do @(posedge clock); while (!req_ready);
      if (b.channel < CHANNELS) begin
         if (b.op == mfa_pkg::OP_LOAD) begin
            if (b.tap_index < TAPS)
               coef_mem[b.channel][b.tap_index] = b.coef_value;
            load_count++;
         end else begin
            pending_outputs.push_back(fir_output(b.channel, b.sample_in, b.addend));
            sample_count++;
         end
      end
   endtask

   task automatic wait_for_outputs();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_outputs.size() != 0);
   endtask

   task automatic load_channel(input int ch, input coef_set_type kind);
      int k;
      chan_set[ch] = kind;
      for (k = 0; k < TAPS; k++)
         send_beat(load_beat(ch, k, coef_for(kind, k)));
   endtask

   // tap 0 = 0.5, so each result is addend + x/2: exercises half-up rounding
   task automatic test_rounding();
      load_channel(0, COEFS_HALF_DELTA);
      send_beat(sample_beat(0, word_type'(1), '0));
      send_beat(sample_beat(0, word_type'(-1), '0));
      send_beat(sample_beat(0, word_type'(3), '0));
      send_beat(sample_beat(0, word_type'(-3), '0));
      send_beat(sample_beat(0, WORD_MAX, '0));
      send_beat(sample_beat(0, WORD_MIN, '0));
      send_beat(sample_beat(0, word_type'(-1), WORD_MAX));
      send_beat(sample_beat(0, word_type'(1), WORD_MIN));
      send_beat(sample_beat(0, word_type'(2), WORD_MAX));
      send_beat(sample_beat(0, word_type'(-2), WORD_MIN));
      send_beat(sample_beat(0, WORD_MIN, WORD_MIN));
   endtask

   // all taps -1.0: result is addend minus the running history sum
   task automatic test_saturation();
      load_channel(1, COEFS_ALL_MIN);
      send_beat(sample_beat(1, WORD_MIN, '0));
      send_beat(sample_beat(1, WORD_MAX, '0));
      send_beat(sample_beat(1, WORD_MAX, WORD_MIN));
      send_beat(sample_beat(1, '0, WORD_MAX));
      send_beat(sample_beat(1, WORD_MIN, WORD_MAX));
   endtask

   task automatic test_coef_edges();
      send_beat(load_beat(0, 0, WORD_MAX));
      send_beat(load_beat(0, TAPS - 1, WORD_MIN));
      send_beat(load_beat(1, TAPS - 1, WORD_MAX));
      send_beat(load_beat(1, 0, WORD_MIN));
      send_beat(sample_beat(0, WORD_MAX, '0));
      send_beat(sample_beat(1, WORD_MIN, word_type'(-1)));
   endtask

   // receiver holds off long enough for a result to back up and the
   // request side to stall
   task automatic test_backpressure();
      wait_for_outputs();
      tx_mode = TX_STEADY;
      rx_hold_req++;
      repeat (4) send_beat(sample_beat(1, pick_word(), pick_word()));
      wait_for_outputs();
      tx_mode = TX_BURSTY;
   endtask

   task automatic run_phase(input coef_set_type set0, input coef_set_type set1,
                            input tx_mode_type tx, input rx_mode_type rx);
      int i;
      int ch;
      wait_for_outputs();
      tx_mode = TX_BURSTY;
      load_channel(0, set0);
      load_channel(1, set1);
      tx_mode = tx;
      rx_mode = rx;
      for (i = 0; i < RANDOM_ITEMS / 4; i++) begin
         ch = $urandom_range(0, CHANNELS - 1);
         if ($urandom_range(0, 4) == 0)
            send_beat(load_beat(ch, $urandom_range(0, TAPS - 1), coef_for(chan_set[ch], 1)));
         else
            send_beat(sample_beat(ch, pick_word(), pick_word()));
      end
   endtask

   task automatic test_random_traffic();
      run_phase(COEFS_SPARSE, COEFS_SMALL, TX_LONG_GAPS, RX_STALLS);
      run_phase(COEFS_FULL, COEFS_SPARSE, TX_BURSTY, RX_STALLS);
      run_phase(COEFS_SMALL, COEFS_ALL_MAX, TX_STEADY, RX_ALWAYS);
      run_phase(COEFS_SPARSE, COEFS_FULL, TX_LONG_GAPS, RX_STALLS);
   endtask

   // receiver: always ready, alternating ready/stall runs, or a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rx_hold_seen != rx_hold_req) begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = HOLD_OFF_CYCLES;
         end
         if (rx_hold_left != 0) begin
            rx_hold_left--;
            rsp_ready <= 1'b0;
         end else if (rx_mode == RX_ALWAYS) begin
            rsp_ready <= 1'b1;
         end else begin
            if (rx_run_left == 0) begin
               rx_stalling = !rx_stalling;
               rx_run_left = rx_stalling ? $urandom_range(1, 12) : $urandom_range(1, 24);
            end
            rx_run_left--;
            rsp_ready <= !rx_stalling;
         end
      end
   end

   always @(posedge clock) begin
      fir_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (rsp_clipped) clip_count++;
         if (pending_outputs.size() == 0) begin
            $error("response beat with nothing expected: filtered %0d, clipped %0d",
                   rsp_filtered, rsp_clipped);
            fail_count++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_filtered !== want.filtered) begin
               $error("rsp_filtered mismatch: expected %0d, actual %0d",
                      want.filtered, rsp_filtered);
               fail_count++;
            end
            if (rsp_clipped !== want.clipped) begin
               $error("rsp_clipped mismatch: expected %0d, actual %0d",
                      want.clipped, rsp_clipped);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
                  idle_cycles, pending_outputs.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int ch;
      int k;
      for (ch = 0; ch < CHANNELS; ch++) begin
         hist_head[ch] = 0;
         chan_set[ch]  = COEFS_FULL;
         for (k = 0; k < TAPS; k++) begin
            hist_mem[ch][k] = '0;
            coef_mem[ch][k] = '0;
         end
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_rounding();
      test_saturation();
      test_coef_edges();
      test_backpressure();
      test_random_traffic();

      wait_for_outputs();
      repeat (TAPS + 16) @(posedge clock);
      $display("Covered rounding, saturation, tap edges, a long stall, random phases:");
      $display("  %0d loads, %0d samples, %0d results (%0d clipped) on %0d channels",
               load_count, sample_count, result_count, clip_count, CHANNELS);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: multichannel_fir_accumulate_core.f
hw/rtl/mfa_pkg.sv
hw/rtl/mfa_ctrl.sv
hw/rtl/mfa_datapath.sv
hw/rtl/multichannel_fir_accumulate_core.sv
verif/multichannel_fir_accumulate_core_tb.sv
